>>> sv/qrpmm_pkg.sv
// ============================================================================
// qrpmm_pkg - shared types, constants and helpers of the quad rate PID mixer
// Fixed-point formats, register map, stream payload layouts and the setpoint,
// rate error and motor pulse conversions.
// ============================================================================
`default_nettype none

package qrpmm_pkg;

	localparam int FRAC_BITS = 8;
	localparam int GAIN_FRAC = 8;
	localparam int NUM_AXES  = 3;

	localparam int AX_ROLL  = 0;
	localparam int AX_PITCH = 1;
	localparam int AX_YAW   = 2;

	// dead band and yaw arming threshold, microseconds
	localparam logic [11:0] DB_HI   = 12'd1508;
	localparam logic [11:0] DB_LO   = 12'd1492;
	localparam logic [11:0] YAW_ARM = 12'd1050;

	// floor(a * 2^F / 3) = a * SP_MUL + floor(a * SP_REM / 3)
	localparam int SP_MUL     = (1 << FRAC_BITS) / 3;
	localparam int SP_REM     = (1 << FRAC_BITS) % 3;
	localparam int DIV3_MUL   = 43691;
	localparam int DIV3_SHIFT = 17;

	localparam logic signed [23:0] ERR_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] ERR_MIN = 24'sh800000;

	localparam logic signed [14:0] MOTOR_MAX = 15'sd4095;
	localparam logic signed [14:0] MOTOR_MIN = -15'sd2048;
	localparam logic signed [22:0] TRUNC_RND = 23'((1 << FRAC_BITS) - 1);

	// register map, index = paddr[4:2]
	localparam logic [2:0] REG_P_RP    = 3'd0;
	localparam logic [2:0] REG_I_RP    = 3'd1;
	localparam logic [2:0] REG_D_RP    = 3'd2;
	localparam logic [2:0] REG_P_YAW   = 3'd3;
	localparam logic [2:0] REG_I_YAW   = 3'd4;
	localparam logic [2:0] REG_D_YAW   = 3'd5;
	localparam logic [2:0] REG_OUT_LIM = 3'd6;
	localparam logic [2:0] REG_THR_CAP = 3'd7;

	localparam logic [15:0] RST_P_RP    = 16'd358;
	localparam logic [15:0] RST_I_RP    = 16'd13;
	localparam logic [15:0] RST_D_RP    = 16'd3840;
	localparam logic [15:0] RST_P_YAW   = 16'd1024;
	localparam logic [15:0] RST_I_YAW   = 16'd5;
	localparam logic [15:0] RST_D_YAW   = 16'd0;
	localparam logic [9:0]  RST_OUT_LIM = 10'd400;
	localparam logic [11:0] RST_THR_CAP = 12'd1800;

	typedef logic signed [23:0] err_t;
	typedef logic signed [19:0] integ_t;
	typedef logic signed [18:0] pid_t;

	typedef struct packed {
		logic signed [15:0] rate_yaw;
		logic signed [15:0] rate_pitch;
		logic signed [15:0] rate_roll;
		logic [11:0]        pulse_yaw;
		logic [11:0]        pulse_throttle;
		logic [11:0]        pulse_pitch;
		logic [11:0]        pulse_roll;
	} in_t;

	typedef struct packed {
		logic [3:0]         pad;
		logic signed [12:0] motor_front_left;
		logic signed [12:0] motor_rear_left;
		logic signed [12:0] motor_rear_right;
		logic signed [12:0] motor_front_right;
	} out_t;

	function automatic pid_t setpoint(input logic [11:0] pulse);
		logic [11:0]        mag;
		logic               neg;
		logic [12:0]        rem_term;
		logic [29:0]        div3;
		logic [19:0]        q;
		logic signed [18:0] s;
		if (pulse > DB_HI) begin
			mag = pulse - DB_HI;
			neg = 1'b0;
		end else if (pulse < DB_LO) begin
			mag = DB_LO - pulse;
			neg = 1'b1;
		end else begin
			mag = 12'd0;
			neg = 1'b0;
		end
		rem_term = 13'(mag) * 13'(SP_REM);
		div3     = 30'(rem_term) * 30'(DIV3_MUL);
		q        = 20'(mag) * 20'(SP_MUL) + 20'(div3 >> DIV3_SHIFT);
		s        = $signed({1'b0, q[17:0]});
		return neg ? -s : s;
	endfunction

	function automatic err_t rate_error(input logic signed [15:0] rate, input pid_t sp);
		logic signed [24:0] e;
		e = 25'($signed({rate, {FRAC_BITS{1'b0}}})) - 25'(sp);
		if (e[24] != e[23]) begin
			return e[24] ? ERR_MIN : ERR_MAX;
		end
		return e[23:0];
	endfunction

	function automatic logic signed [12:0] motor_pulse(input logic signed [22:0] m);
		logic signed [22:0] adj;
		logic signed [14:0] q;
		adj = m[22] ? m + TRUNC_RND : m;
		q   = 15'(adj >>> FRAC_BITS);
		if (q > MOTOR_MAX) begin
			q = MOTOR_MAX;
		end else if (q < MOTOR_MIN) begin
			q = MOTOR_MIN;
		end
		return q[12:0];
	endfunction

endpackage

`default_nettype wire

>>> sv/quad_rate_pid_motor_mixer.sv
// ============================================================================
// quad_rate_pid_motor_mixer - three-axis rate PID with quad-X motor mixer
// Six-stage pipeline: input register, setpoint and error, gain products,
// integrator update, PID clamp, mixer and output register.
// ============================================================================
//
//  channel   dir  transaction                          payload
//  s_axis    in   s_axis_tvalid & s_axis_tready        pulses + gyro rates
//  m_axis    out  m_axis_tvalid & m_axis_tready        four motor pulses
//  apb       in   psel & penable & pwrite & pready     gain / limit registers
//
//  One transaction per cycle sustained while m_axis_tready stays high; m_axis_tvalid is the stage 6 valid.
//  The integrator loop closes inside the integrator stage, so consecutive
//  items update state in back-to-back cycles.
//  Ready is combinational through all stages: a full pipeline stalls s_axis in the
//  same cycle as m_axis_tready drops; empty stages keep filling.
//  Reset clears pipeline valids, integrators and last errors, loads default gains and limits.
// ============================================================================
`default_nettype none

module quad_rate_pid_motor_mixer import qrpmm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// pulse_roll, pulse_pitch, pulse_throttle, pulse_yaw, rate_roll, rate_pitch, rate_yaw
	input  wire logic [95:0] s_axis_tdata,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// motor_front_right, motor_rear_right, motor_rear_left, motor_front_left, zero pad
	output logic [55:0]      m_axis_tdata,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0] p_gain_rp_q, i_gain_rp_q, d_gain_rp_q;
	logic [15:0] p_gain_yaw_q, i_gain_yaw_q, d_gain_yaw_q;
	logic [9:0]  out_lim_q;
	logic [11:0] thr_cap_q;

	logic [2:0] reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_rp_q  <= RST_P_RP;
			i_gain_rp_q  <= RST_I_RP;
			d_gain_rp_q  <= RST_D_RP;
			p_gain_yaw_q <= RST_P_YAW;
			i_gain_yaw_q <= RST_I_YAW;
			d_gain_yaw_q <= RST_D_YAW;
			out_lim_q    <= RST_OUT_LIM;
			thr_cap_q    <= RST_THR_CAP;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_P_RP:    p_gain_rp_q  <= pwdata[15:0];
				REG_I_RP:    i_gain_rp_q  <= pwdata[15:0];
				REG_D_RP:    d_gain_rp_q  <= pwdata[15:0];
				REG_P_YAW:   p_gain_yaw_q <= pwdata[15:0];
				REG_I_YAW:   i_gain_yaw_q <= pwdata[15:0];
				REG_D_YAW:   d_gain_yaw_q <= pwdata[15:0];
				REG_OUT_LIM: out_lim_q    <= pwdata[9:0];
				REG_THR_CAP: thr_cap_q    <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_P_RP:    prdata = {16'd0, p_gain_rp_q};
			REG_I_RP:    prdata = {16'd0, i_gain_rp_q};
			REG_D_RP:    prdata = {16'd0, d_gain_rp_q};
			REG_P_YAW:   prdata = {16'd0, p_gain_yaw_q};
			REG_I_YAW:   prdata = {16'd0, i_gain_yaw_q};
			REG_D_YAW:   prdata = {16'd0, d_gain_yaw_q};
			REG_OUT_LIM: prdata = {22'd0, out_lim_q};
			REG_THR_CAP: prdata = {20'd0, thr_cap_q};
			default:     prdata = 32'd0;
		endcase
	end

	// per-axis gains
	logic [15:0] kp [NUM_AXES];
	logic [15:0] ki [NUM_AXES];
	logic [15:0] kd [NUM_AXES];

	always_comb begin
		kp[AX_ROLL]  = p_gain_rp_q;
		kp[AX_PITCH] = p_gain_rp_q;
		kp[AX_YAW]   = p_gain_yaw_q;
		ki[AX_ROLL]  = i_gain_rp_q;
		ki[AX_PITCH] = i_gain_rp_q;
		ki[AX_YAW]   = i_gain_yaw_q;
		kd[AX_ROLL]  = d_gain_rp_q;
		kd[AX_PITCH] = d_gain_rp_q;
		kd[AX_YAW]   = d_gain_yaw_q;
	end

	logic [17:0]        lim;
	logic signed [18:0] lim_s;

	assign lim   = {out_lim_q, {FRAC_BITS{1'b0}}};
	assign lim_s = $signed({1'b0, lim});

	// pipeline flow control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !vld_s6 || m_axis_tready;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign s_axis_tready = rdy_s1;
	assign m_axis_tvalid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_axis_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: input register
	in_t in_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) in_s1 <= s_axis_tdata;
	end

	// stage 2: setpoints, rate errors, throttle cap
	err_t        err_c [NUM_AXES];
	err_t        err_s2 [NUM_AXES];
	logic [11:0] thr_c, thr_s2;
	pid_t        sp_yaw;

	always_comb begin
		sp_yaw = (in_s1.pulse_throttle > YAW_ARM) ? setpoint(in_s1.pulse_yaw) : '0;
		err_c[AX_ROLL]  = rate_error(in_s1.rate_roll, setpoint(in_s1.pulse_roll));
		err_c[AX_PITCH] = rate_error(in_s1.rate_pitch, setpoint(in_s1.pulse_pitch));
		err_c[AX_YAW]   = rate_error(in_s1.rate_yaw, sp_yaw);
		thr_c = (in_s1.pulse_throttle > thr_cap_q) ? thr_cap_q : in_s1.pulse_throttle;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			err_s2 <= err_c;
			thr_s2 <= thr_c;
		end
	end

	// stage 3: gain products, last error update
	err_t               prev_err_q [NUM_AXES];
	logic signed [32:0] p_c [NUM_AXES];
	logic signed [32:0] i_c [NUM_AXES];
	logic signed [33:0] d_c [NUM_AXES];
	logic signed [32:0] p_s3 [NUM_AXES];
	logic signed [32:0] i_s3 [NUM_AXES];
	logic signed [33:0] d_s3 [NUM_AXES];
	logic [11:0]        thr_s3;

	always_comb begin
		logic signed [24:0] diff;
		logic signed [40:0] pprod, iprod;
		logic signed [41:0] dprod;
		for (int a = 0; a < NUM_AXES; a++) begin
			diff   = 25'(err_s2[a]) - 25'(prev_err_q[a]);
			pprod  = 41'($signed({1'b0, kp[a]})) * 41'(err_s2[a]);
			iprod  = 41'($signed({1'b0, ki[a]})) * 41'(err_s2[a]);
			dprod  = 42'($signed({1'b0, kd[a]})) * 42'(diff);
			p_c[a] = 33'(pprod >>> GAIN_FRAC);
			i_c[a] = 33'(iprod >>> GAIN_FRAC);
			d_c[a] = 34'(dprod >>> GAIN_FRAC);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			p_s3   <= p_c;
			i_s3   <= i_c;
			d_s3   <= d_c;
			thr_s3 <= thr_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) prev_err_q[a] <= '0;
		end else if (rdy_s3 && vld_s2) begin
			prev_err_q <= err_s2;
		end
	end

	// stage 4: integrator update, P + D
	integ_t             integ_q [NUM_AXES];
	integ_t             integ_c [NUM_AXES];
	integ_t             integ_s4 [NUM_AXES];
	logic signed [34:0] pd_c [NUM_AXES];
	logic signed [34:0] pd_s4 [NUM_AXES];
	logic [11:0]        thr_s4;

	always_comb begin
		logic signed [33:0] isum;
		for (int a = 0; a < NUM_AXES; a++) begin
			isum = 34'(integ_q[a]) + 34'(i_s3[a]);
			if (isum > 34'(lim_s)) begin
				integ_c[a] = 20'(lim_s);
			end else if (isum < -34'(lim_s)) begin
				integ_c[a] = 20'(-lim_s);
			end else begin
				integ_c[a] = isum[19:0];
			end
			pd_c[a] = 35'(p_s3[a]) + 35'(d_s3[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			integ_s4 <= integ_c;
			pd_s4    <= pd_c;
			thr_s4   <= thr_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) integ_q[a] <= '0;
		end else if (rdy_s4 && vld_s3) begin
			integ_q <= integ_c;
		end
	end

	// stage 5: PID sum and output clamp
	pid_t        pid_c [NUM_AXES];
	pid_t        pid_s5 [NUM_AXES];
	logic [11:0] thr_s5;

	always_comb begin
		logic signed [35:0] osum;
		for (int a = 0; a < NUM_AXES; a++) begin
			osum = 36'(pd_s4[a]) + 36'(integ_s4[a]);
			if (osum > 36'(lim_s)) begin
				pid_c[a] = lim_s;
			end else if (osum < -36'(lim_s)) begin
				pid_c[a] = -lim_s;
			end else begin
				pid_c[a] = osum[18:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			pid_s5 <= pid_c;
			thr_s5 <= thr_s4;
		end
	end

	// stage 6: quad-X mix, output register
	logic signed [22:0] t_m, r_m, p_m, y_m;
	out_t               out_c, out_s6;

	always_comb begin
		t_m = $signed({3'd0, thr_s5, {FRAC_BITS{1'b0}}});
		r_m = 23'(pid_s5[AX_ROLL]);
		p_m = 23'(pid_s5[AX_PITCH]);
		y_m = 23'(pid_s5[AX_YAW]);
		out_c.pad               = '0;
		out_c.motor_front_right = motor_pulse(t_m - p_m + r_m - y_m);
		out_c.motor_rear_right  = motor_pulse(t_m + p_m + r_m + y_m);
		out_c.motor_rear_left   = motor_pulse(t_m + p_m - r_m - y_m);
		out_c.motor_front_left  = motor_pulse(t_m - p_m - r_m + y_m);
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) out_s6 <= out_c;
	end

	assign m_axis_tdata = out_s6;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s1)
		else $error("accepted transaction did not reach the input register");

	a_prev_err_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && rdy_s3) |=> (prev_err_q[AX_ROLL] == $past(err_s2[AX_ROLL]) &&
			prev_err_q[AX_YAW] == $past(err_s2[AX_YAW])))
		else $error("last error not taken from the item leaving stage 2");

	a_integ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s3 && rdy_s4) |=> ($stable(integ_q[AX_ROLL]) && $stable(integ_q[AX_PITCH]) &&
			$stable(integ_q[AX_YAW])))
		else $error("integrator changed without an item in stage 3");

endmodule

`default_nettype wire
